### rtl/rasu_pkg.sv
// ----------------------------------------------------------------------------
// rasu_pkg
// Shared types, register indexes and small modulo helpers for the alarm
// countdown block.
// ----------------------------------------------------------------------------
package rasu_pkg;

    typedef logic signed [9:0] t_val;

    localparam int unsigned NUM_STAGES = 6;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned OUT_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_BINARY_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_FORMAT_24 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALM_SECOND     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALM_MINUTE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALM_HOUR       = 3'd4;

    localparam t_val VAL_DONT_CARE = -10'sd1;

    // x mod 24 for x below 192
    function automatic logic [7:0] mod24_u8(input logic [7:0] x);
        logic [7:0] y;
        y = x;
        if (y >= 8'd96) y = y - 8'd96;
        if (y >= 8'd48) y = y - 8'd48;
        if (y >= 8'd24) y = y - 8'd24;
        return y;
    endfunction

    // x mod 12 for x below 192
    function automatic logic [7:0] mod12_u8(input logic [7:0] x);
        logic [7:0] y;
        y = mod24_u8(x);
        if (y >= 8'd12) y = y - 8'd12;
        return y;
    endfunction

    // truncating mod 60, negative values pass through
    function automatic t_val smod60(input t_val x);
        logic [7:0] y;
        y = x[7:0];
        if (y >= 8'd120) y = y - 8'd120;
        if (y >= 8'd60) y = y - 8'd60;
        return (x < 10'sd0) ? x : t_val'({2'b00, y});
    endfunction

    // truncating mod 24, negative values pass through
    function automatic t_val smod24(input t_val x);
        logic [7:0] y;
        y = mod24_u8(x[7:0]);
        return (x < 10'sd0) ? x : t_val'({2'b00, y});
    endfunction

endpackage

### rtl/rtc_alarm_seconds_until_unit.sv
// ----------------------------------------------------------------------------
// rtc_alarm_seconds_until_unit
// Seconds from the current clock reading to the next alarm match.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries the current second,
//   minute and hour register bytes. Output channel (o_out_valid /
//   i_out_ready) returns one count, 1..86400, per request, in order.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the
//   mode bits and the alarm bytes; write it only while the block is idle.
//   The six register stages are decode, alarm resolution, normalization,
//   differences, weighted sum, day wrap, the first loaded at acceptance.
//   Throughput is one request per cycle while the receiver keeps up; every
//   stage has its own valid bit and a stage loads whenever it is empty or
//   the stage after it moves.
//   When the receiver stalls, results pile up in the stages; o_in_ready
//   drops only once all six stages are full, nothing is lost or repeated.
//   Reset clears all valid bits and sets the registers to BCD, 24-hour
//   format and alarm bytes of zero.
// ----------------------------------------------------------------------------
module rtc_alarm_seconds_until_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_now_second_byte,
    input  logic [7:0]                        i_now_minute_byte,
    input  logic [7:0]                        i_now_hour_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rasu_pkg::OUT_W-1:0]        o_seconds_to_alarm,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rasu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rasu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned NS = rasu_pkg::NUM_STAGES;

    logic       r_binary_mode;
    logic       r_hour_format_24;
    logic [7:0] r_alm_second;
    logic [7:0] r_alm_minute;
    logic [7:0] r_alm_hour;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_rdy;

    rasu_pkg::t_val w_as, w_am, w_ah, w_cs, w_cm, w_ch;

    rasu_pkg::t_val r_s1_as, r_s1_am, r_s1_ah, r_s1_cs, r_s1_cm, r_s1_ch;
    rasu_pkg::t_val r_s2_as, r_s2_am, r_s2_ah, r_s2_cs, r_s2_cm, r_s2_ch;
    rasu_pkg::t_val r_s3_as, r_s3_am, r_s3_ah, r_s3_cs, r_s3_cm, r_s3_ch;
    logic [4:0]         r_s4_hm;
    logic signed [10:0] r_s4_md, r_s4_sd;
    logic signed [17:0] r_s5_t;
    logic [rasu_pkg::OUT_W-1:0] r_s6_out;

    rasu_pkg::t_val n_s2_as, n_s2_am, n_s2_ah;
    rasu_pkg::t_val n_s3_as, n_s3_am, n_s3_ah;
    logic signed [10:0] n_hd, n_hx, n_md, n_sd;
    logic [4:0]         n_hm;
    logic signed [17:0] n_t, n_r;
    logic [rasu_pkg::OUT_W-1:0] n_out;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode    <= 1'b0;
            r_hour_format_24 <= 1'b1;
            r_alm_second     <= 8'd0;
            r_alm_minute     <= 8'd0;
            r_alm_hour       <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rasu_pkg::CFG_BINARY_MODE:    r_binary_mode    <= i_cfg_data[0];
                rasu_pkg::CFG_HOUR_FORMAT_24: r_hour_format_24 <= i_cfg_data[0];
                rasu_pkg::CFG_ALM_SECOND:     r_alm_second     <= i_cfg_data;
                rasu_pkg::CFG_ALM_MINUTE:     r_alm_minute     <= i_cfg_data;
                rasu_pkg::CFG_ALM_HOUR:       r_alm_hour       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake
    always_comb begin
        w_rdy[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: field decode
    rasu_field_dec u_dec_as (.i_byte(r_alm_second), .i_is_hour(1'b0),
        .i_binary_mode(r_binary_mode), .i_hour_format_24(r_hour_format_24), .o_value(w_as));
    rasu_field_dec u_dec_am (.i_byte(r_alm_minute), .i_is_hour(1'b0),
        .i_binary_mode(r_binary_mode), .i_hour_format_24(r_hour_format_24), .o_value(w_am));
    rasu_field_dec u_dec_ah (.i_byte(r_alm_hour), .i_is_hour(1'b1),
        .i_binary_mode(r_binary_mode), .i_hour_format_24(r_hour_format_24), .o_value(w_ah));
    rasu_field_dec u_dec_cs (.i_byte(i_now_second_byte), .i_is_hour(1'b0),
        .i_binary_mode(r_binary_mode), .i_hour_format_24(r_hour_format_24), .o_value(w_cs));
    rasu_field_dec u_dec_cm (.i_byte(i_now_minute_byte), .i_is_hour(1'b0),
        .i_binary_mode(r_binary_mode), .i_hour_format_24(r_hour_format_24), .o_value(w_cm));
    rasu_field_dec u_dec_ch (.i_byte(i_now_hour_byte), .i_is_hour(1'b1),
        .i_binary_mode(r_binary_mode), .i_hour_format_24(r_hour_format_24), .o_value(w_ch));

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_as <= w_as;
            r_s1_am <= w_am;
            r_s1_ah <= w_ah;
            r_s1_cs <= w_cs;
            r_s1_cm <= w_cm;
            r_s1_ch <= w_ch;
        end
    end

    // stage 2: don't-care resolution
    always_comb begin
        n_s2_as = r_s1_as;
        n_s2_am = r_s1_am;
        n_s2_ah = r_s1_ah;
        if (r_s1_ah == rasu_pkg::VAL_DONT_CARE) begin
            n_s2_ah = r_s1_ch;
            if (r_s1_am == rasu_pkg::VAL_DONT_CARE) begin
                n_s2_am = r_s1_cm;
                if (r_s1_as == rasu_pkg::VAL_DONT_CARE) begin
                    n_s2_as = r_s1_cs + 10'sd1;
                end else if (r_s1_cs > r_s1_as) begin
                    n_s2_am = n_s2_am + 10'sd1;
                end
            end else if (r_s1_cm == r_s1_am) begin
                if (r_s1_as == rasu_pkg::VAL_DONT_CARE) begin
                    n_s2_as = r_s1_cs + 10'sd1;
                end else if (r_s1_cs > r_s1_as) begin
                    n_s2_ah = n_s2_ah + 10'sd1;
                end
                if (n_s2_as == 10'sd60) begin
                    n_s2_as = 10'sd0;
                    n_s2_ah = n_s2_ah + 10'sd1;
                end
            end else if (r_s1_cm > r_s1_am) begin
                n_s2_ah = n_s2_ah + 10'sd1;
            end
        end else if (r_s1_ch == r_s1_ah) begin
            if (r_s1_am == rasu_pkg::VAL_DONT_CARE) begin
                n_s2_am = r_s1_cm;
                if (r_s1_as == rasu_pkg::VAL_DONT_CARE) begin
                    n_s2_as = r_s1_cs + 10'sd1;
                end else if (r_s1_cs > r_s1_as) begin
                    n_s2_am = n_s2_am + 10'sd1;
                end
                if (n_s2_as == 10'sd60) begin
                    n_s2_as = 10'sd0;
                    n_s2_am = n_s2_am + 10'sd1;
                end
                n_s2_am = rasu_pkg::smod60(n_s2_am);
            end else if (r_s1_cm == r_s1_am) begin
                if (r_s1_as == rasu_pkg::VAL_DONT_CARE) begin
                    n_s2_as = r_s1_cs + 10'sd1;
                end
                n_s2_as = rasu_pkg::smod60(n_s2_as);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2_as <= n_s2_as;
            r_s2_am <= n_s2_am;
            r_s2_ah <= n_s2_ah;
            r_s2_cs <= r_s1_cs;
            r_s2_cm <= r_s1_cm;
            r_s2_ch <= r_s1_ch;
        end
    end

    // stage 3: carry and hour wrap
    always_comb begin
        n_s3_as = r_s2_as;
        n_s3_am = r_s2_am;
        n_s3_ah = r_s2_ah;
        if (n_s3_am == rasu_pkg::VAL_DONT_CARE) n_s3_am = 10'sd0;
        if (n_s3_as == rasu_pkg::VAL_DONT_CARE) n_s3_as = 10'sd0;
        if (n_s3_as == 10'sd60) begin
            n_s3_as = 10'sd0;
            n_s3_am = n_s3_am + 10'sd1;
        end
        if (n_s3_am == 10'sd60) begin
            n_s3_am = 10'sd0;
            n_s3_ah = n_s3_ah + 10'sd1;
        end
        n_s3_ah = rasu_pkg::smod24(n_s3_ah);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s3_as <= n_s3_as;
            r_s3_am <= n_s3_am;
            r_s3_ah <= n_s3_ah;
            r_s3_cs <= r_s2_cs;
            r_s3_cm <= r_s2_cm;
            r_s3_ch <= r_s2_ch;
        end
    end

    // stage 4: field differences, hour difference taken mod 24
    always_comb begin
        n_hd = 11'(r_s3_ah) - 11'(r_s3_ch);
        n_hx = n_hd + 11'sd144;
        n_hm = 5'(rasu_pkg::mod24_u8(n_hx[7:0]));
        n_md = 11'(r_s3_am) - 11'(r_s3_cm);
        n_sd = 11'(r_s3_as) - 11'(r_s3_cs);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s4_hm <= n_hm;
            r_s4_md <= n_md;
            r_s4_sd <= n_sd;
        end
    end

    // stage 5: weighted sum minus one
    assign n_t = $signed(18'(r_s4_hm) * 18'd3600) + 18'(r_s4_md) * 18'sd60
               + 18'(r_s4_sd) - 18'sd1;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) r_s5_t <= n_t;
    end

    // stage 6: wrap into one day
    always_comb begin
        n_r = r_s5_t;
        if (r_s5_t < 18'sd0) begin
            n_r = r_s5_t + 18'sd86400;
        end else if (r_s5_t >= 18'sd86400) begin
            n_r = r_s5_t - 18'sd86400;
        end
        n_out = 17'(n_r) + 17'd1;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) r_s6_out <= n_out;
    end

    assign o_seconds_to_alarm = r_s6_out;

    // checks
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_seconds_to_alarm >= 17'd1 && o_seconds_to_alarm <= 17'd86400))
        else $error("count out of range");

    a_hour_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s3_ah >= rasu_pkg::VAL_DONT_CARE && r_s3_ah < 10'sd24))
        else $error("hour not wrapped");

    a_hour_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_s4_hm < 5'd24))
        else $error("hour difference not reduced");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_in_ready)
        else $error("input stalled with empty first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

### rtl/rasu_field_dec.sv
// ----------------------------------------------------------------------------
// rasu_field_dec
// Decodes one raw time register byte (BCD or binary, 12/24-hour hours) into
// a signed value, with don't-care bytes decoded as -1.
// ----------------------------------------------------------------------------
module rasu_field_dec (
    input  logic [7:0]      i_byte,
    input  logic            i_is_hour,
    input  logic            i_binary_mode,
    input  logic            i_hour_format_24,
    output rasu_pkg::t_val  o_value
);

    logic [7:0] w_masked;
    logic [7:0] w_dec;
    logic [7:0] w_hour12;

    always_comb begin
        w_masked = i_is_hour ? {1'b0, i_byte[6:0]} : i_byte;
        if (i_binary_mode) begin
            w_dec = w_masked;
        end else begin
            w_dec = 8'(w_masked[7:4] * 8'd10) + 8'(w_masked[3:0]);
        end
        w_hour12 = rasu_pkg::mod12_u8(w_dec) + (i_byte[7] ? 8'd12 : 8'd0);
        if (i_byte[7:6] == 2'b11) begin
            o_value = rasu_pkg::VAL_DONT_CARE;
        end else if (i_is_hour && !i_hour_format_24) begin
            o_value = rasu_pkg::t_val'({2'b00, w_hour12});
        end else begin
            o_value = rasu_pkg::t_val'({2'b00, w_dec});
        end
    end

endmodule
